/* hdl/ctd_pkg.sv */
`default_nettype none

package ctd_pkg;

    localparam int LIMIT_W = 24;

    localparam logic [LIMIT_W-1:0] MAX_TOTAL_RST = 24'd8388608;

    // action codes
    localparam logic [1:0] ACT_BYTE    = 2'd0;
    localparam logic [1:0] ACT_CLOSE   = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // event codes
    localparam logic [1:0] EV_BYTE     = 2'd0;
    localparam logic [1:0] EV_COMPLETE = 2'd1;
    localparam logic [1:0] EV_ERROR    = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_CHAR  = 3'd1;
    localparam logic [2:0] ERR_EMPTY     = 3'd2;
    localparam logic [2:0] ERR_SIZE_BIG  = 3'd3;
    localparam logic [2:0] ERR_NO_CRLF   = 3'd4;
    localparam logic [2:0] ERR_TOTAL_BIG = 3'd5;
    localparam logic [2:0] ERR_CLOSED    = 3'd6;

    localparam logic [7:0] CHAR_CR   = 8'h0d;
    localparam logic [7:0] CHAR_LF   = 8'h0a;
    localparam logic [7:0] CHAR_SEMI = 8'h3b;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_9    = 8'h39;
    localparam logic [7:0] CHAR_LA   = 8'h61;
    localparam logic [7:0] CHAR_LF_A = 8'h66;
    localparam logic [7:0] CHAR_UA   = 8'h41;
    localparam logic [7:0] CHAR_UF   = 8'h46;

    typedef enum logic [2:0] {
        PH_SIZE  = 3'd0,
        PH_EXT   = 3'd1,
        PH_DATA  = 3'd2,
        PH_DCR   = 3'd3,
        PH_DLF   = 3'd4,
        PH_TRAIL = 3'd5,
        PH_FINAL = 3'd6
    } t_phase;

    typedef struct packed {
        t_phase phase;
        logic   saw_digit;
        logic   prev_was_cr;
        logic   line_empty;
    } t_ctl;

    typedef struct packed {
        logic       valid;
        logic [1:0] event_res;
        logic [7:0] payload;
        logic [2:0] error_code;
    } t_result;

    localparam t_ctl CTL_CLEAR = '{
        phase: PH_SIZE, saw_digit: 1'b0, prev_was_cr: 1'b0, line_empty: 1'b1
    };

    // bit 4 set when the byte is a hex digit, low bits hold its value
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [7:0] t;
        t = 8'd0;
        if (b >= CHAR_0 && b <= CHAR_9) begin
            t = b - CHAR_0;
            return {1'b1, t[3:0]};
        end else if (b >= CHAR_LA && b <= CHAR_LF_A) begin
            t = b - CHAR_LA + 8'd10;
            return {1'b1, t[3:0]};
        end else if (b >= CHAR_UA && b <= CHAR_UF) begin
            t = b - CHAR_UA + 8'd10;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

`default_nettype wire

/* hdl/chunked_transfer_decoder.sv */
`default_nettype none

// a result is registered and appears on the output in the cycle after its item is taken
// throughput: one item per cycle, limited only by the single output register
// each item is decoded in one pass of ctd_step between the state and result registers
// reset (synchronous, active low) returns to the size line with max_total = 8388608
// restart clears the parse state and keeps max_total

module chunked_transfer_decoder #(
    parameter int COUNT_WIDTH = 24
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [1:0]                  i_action,
    input  wire logic [7:0]                  i_data_byte,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [1:0]                       o_event_res,
    output logic [7:0]                       o_payload,
    output logic [2:0]                       o_error_code,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [ctd_pkg::LIMIT_W-1:0] i_cfg_max_total
);
    import ctd_pkg::*;

    localparam logic [32:0] CNT_MASK = (33'd1 << COUNT_WIDTH) - 33'd1;
    localparam logic [LIMIT_W-1:0] RST_LIMIT =
        (33'(MAX_TOTAL_RST) > CNT_MASK) ? CNT_MASK[LIMIT_W-1:0] : MAX_TOTAL_RST;

    t_ctl                   r_ctl;
    t_ctl                   n_ctl;
    logic [COUNT_WIDTH-1:0] r_size_accum;
    logic [COUNT_WIDTH-1:0] n_size_accum;
    logic [COUNT_WIDTH-1:0] r_bytes_left;
    logic [COUNT_WIDTH-1:0] n_bytes_left;
    logic [COUNT_WIDTH-1:0] r_total_out;
    logic [COUNT_WIDTH-1:0] n_total_out;
    logic [LIMIT_W-1:0]     r_limit;
    logic [LIMIT_W-1:0]     n_limit;
    t_result                n_res;
    logic                   r_out_valid;
    logic [1:0]             r_event_res;
    logic [7:0]             r_payload;
    logic [2:0]             r_error_code;
    logic                   in_xfer;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && o_in_ready;

    // clamp the written ceiling to what the counters can hold
    assign n_limit = ({9'd0, i_cfg_max_total} > CNT_MASK) ?
        CNT_MASK[LIMIT_W-1:0] : i_cfg_max_total;

    ctd_step #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_step (
        .i_ctl        (r_ctl),
        .i_size_accum (r_size_accum),
        .i_bytes_left (r_bytes_left),
        .i_total_out  (r_total_out),
        .i_limit      (r_limit),
        .i_action     (i_action),
        .i_data_byte  (i_data_byte),
        .o_ctl        (n_ctl),
        .o_size_accum (n_size_accum),
        .o_bytes_left (n_bytes_left),
        .o_total_out  (n_total_out),
        .o_res        (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl        <= CTL_CLEAR;
            r_size_accum <= '0;
            r_bytes_left <= '0;
            r_total_out  <= '0;
            r_limit      <= RST_LIMIT;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= n_limit;
            end
            if (in_xfer) begin
                r_ctl        <= n_ctl;
                r_size_accum <= n_size_accum;
                r_bytes_left <= n_bytes_left;
                r_total_out  <= n_total_out;
                r_out_valid  <= n_res.valid;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_event_res  <= n_res.event_res;
            r_payload    <= n_res.payload;
            r_error_code <= n_res.error_code;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_res  = r_event_res;
    assign o_payload    = r_payload;
    assign o_error_code = r_error_code;

    a_final_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && n_res.valid && n_res.event_res != EV_BYTE |=> r_ctl.phase == PH_FINAL)
        else $error("no final phase after completion or error");

    a_data_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.phase == PH_DATA |-> r_bytes_left != '0)
        else $error("data phase with no bytes left");

    a_byte_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_event_res == EV_BYTE |-> r_error_code == ERR_NONE)
        else $error("payload transfer carries an error code");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while result is stalled");

endmodule

`default_nettype wire

/* hdl/ctd_step.sv */
`default_nettype none

module ctd_step #(
    parameter int COUNT_WIDTH = 24
) (
    input  wire ctd_pkg::t_ctl               i_ctl,
    input  wire logic [COUNT_WIDTH-1:0]      i_size_accum,
    input  wire logic [COUNT_WIDTH-1:0]      i_bytes_left,
    input  wire logic [COUNT_WIDTH-1:0]      i_total_out,
    input  wire logic [ctd_pkg::LIMIT_W-1:0] i_limit,
    input  wire logic [1:0]                  i_action,
    input  wire logic [7:0]                  i_data_byte,
    output ctd_pkg::t_ctl                    o_ctl,
    output logic [COUNT_WIDTH-1:0]           o_size_accum,
    output logic [COUNT_WIDTH-1:0]           o_bytes_left,
    output logic [COUNT_WIDTH-1:0]           o_total_out,
    output ctd_pkg::t_result                 o_res
);
    import ctd_pkg::*;

    localparam int CMP_W = ((COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W) + 4;

    logic [4:0]       hex;
    logic [CMP_W-1:0] size_next;
    logic [CMP_W-1:0] lim_ext;
    logic [CMP_W-1:0] total_next;
    logic             size_big;
    logic             total_big;
    logic             is_byte;
    logic             eol;

    assign hex        = hex_nibble(i_data_byte);
    assign lim_ext    = CMP_W'(i_limit);
    assign size_next  = (CMP_W'(i_size_accum) << 4) + CMP_W'(hex[3:0]);
    assign total_next = CMP_W'(i_total_out) + CMP_W'(i_size_accum) + CMP_W'(1);
    assign size_big   = size_next > lim_ext;
    assign total_big  = total_next > lim_ext;
    assign is_byte    = i_action == ACT_BYTE;

    // CRLF that closes the size line, with or without extension
    assign eol = is_byte && i_ctl.prev_was_cr && i_data_byte == CHAR_LF
        && (i_ctl.phase == PH_SIZE || i_ctl.phase == PH_EXT);

    always_comb begin : next_state
        o_ctl        = i_ctl;
        o_size_accum = i_size_accum;
        o_bytes_left = i_bytes_left;
        o_total_out  = i_total_out;
        unique case (i_action)
            ACT_BYTE: begin
                unique case (i_ctl.phase)
                    PH_SIZE: begin
                        if (i_ctl.prev_was_cr) begin
                            if (i_data_byte != CHAR_LF) begin
                                o_ctl.phase = PH_FINAL;
                            end
                        end else if (i_data_byte == CHAR_CR) begin
                            o_ctl.prev_was_cr = 1'b1;
                        end else if (i_data_byte == CHAR_SEMI) begin
                            o_ctl.phase = i_ctl.saw_digit ? PH_EXT : PH_FINAL;
                        end else if (!hex[4] || size_big) begin
                            o_ctl.phase = PH_FINAL;
                        end else begin
                            o_size_accum    = size_next[COUNT_WIDTH-1:0];
                            o_ctl.saw_digit = 1'b1;
                        end
                    end
                    PH_EXT: begin
                        o_ctl.prev_was_cr = i_data_byte == CHAR_CR;
                    end
                    PH_DATA: begin
                        o_bytes_left = i_bytes_left - COUNT_WIDTH'(1);
                        o_total_out  = i_total_out + COUNT_WIDTH'(1);
                        if (i_bytes_left == COUNT_WIDTH'(1)) begin
                            o_ctl.phase = PH_DCR;
                        end
                    end
                    PH_DCR: begin
                        o_ctl.phase = (i_data_byte == CHAR_CR) ? PH_DLF : PH_FINAL;
                    end
                    PH_DLF: begin
                        if (i_data_byte == CHAR_LF) begin
                            o_ctl.phase       = PH_SIZE;
                            o_size_accum      = '0;
                            o_ctl.saw_digit   = 1'b0;
                            o_ctl.prev_was_cr = 1'b0;
                        end else begin
                            o_ctl.phase = PH_FINAL;
                        end
                    end
                    PH_TRAIL: begin
                        if (i_ctl.prev_was_cr && i_data_byte == CHAR_LF) begin
                            if (i_ctl.line_empty) begin
                                o_ctl.phase = PH_FINAL;
                            end else begin
                                o_ctl.line_empty  = 1'b1;
                                o_ctl.prev_was_cr = 1'b0;
                            end
                        end else if (i_data_byte == CHAR_CR) begin
                            if (i_ctl.prev_was_cr) begin
                                o_ctl.line_empty = 1'b0;
                            end
                            o_ctl.prev_was_cr = 1'b1;
                        end else begin
                            o_ctl.line_empty  = 1'b0;
                            o_ctl.prev_was_cr = 1'b0;
                        end
                    end
                    default: ;
                endcase
                if (eol) begin
                    o_ctl.prev_was_cr = 1'b0;
                    if (!i_ctl.saw_digit) begin
                        o_ctl.phase = PH_FINAL;
                    end else if (i_size_accum == '0) begin
                        o_ctl.phase      = PH_TRAIL;
                        o_ctl.line_empty = 1'b1;
                    end else if (total_big) begin
                        o_ctl.phase = PH_FINAL;
                    end else begin
                        o_bytes_left = i_size_accum;
                        o_ctl.phase  = PH_DATA;
                    end
                end
            end
            ACT_CLOSE: begin
                o_ctl.phase = PH_FINAL;
            end
            ACT_RESTART: begin
                o_ctl        = CTL_CLEAR;
                o_size_accum = '0;
                o_bytes_left = '0;
                o_total_out  = '0;
            end
            default: ;
        endcase
    end

    always_comb begin : result
        o_res = '{valid: 1'b0, event_res: EV_BYTE, payload: 8'd0, error_code: ERR_NONE};
        if (is_byte) begin
            unique case (i_ctl.phase)
                PH_SIZE: begin
                    if (i_ctl.prev_was_cr) begin
                        if (i_data_byte != CHAR_LF) begin
                            o_res.error_code = ERR_BAD_CHAR;
                        end
                    end else if (i_data_byte == CHAR_CR) begin
                        o_res.error_code = ERR_NONE;
                    end else if (i_data_byte == CHAR_SEMI) begin
                        if (!i_ctl.saw_digit) begin
                            o_res.error_code = ERR_EMPTY;
                        end
                    end else if (!hex[4]) begin
                        o_res.error_code = ERR_BAD_CHAR;
                    end else if (size_big) begin
                        o_res.error_code = ERR_SIZE_BIG;
                    end
                end
                PH_DATA: begin
                    o_res.valid   = 1'b1;
                    o_res.payload = i_data_byte;
                end
                PH_DCR: begin
                    if (i_data_byte != CHAR_CR) begin
                        o_res.error_code = ERR_NO_CRLF;
                    end
                end
                PH_DLF: begin
                    if (i_data_byte != CHAR_LF) begin
                        o_res.error_code = ERR_NO_CRLF;
                    end
                end
                PH_TRAIL: begin
                    if (i_ctl.prev_was_cr && i_data_byte == CHAR_LF && i_ctl.line_empty) begin
                        o_res.valid     = 1'b1;
                        o_res.event_res = EV_COMPLETE;
                    end
                end
                default: ;
            endcase
            if (eol) begin
                if (!i_ctl.saw_digit) begin
                    o_res.error_code = ERR_EMPTY;
                end else if (i_size_accum != '0 && total_big) begin
                    o_res.error_code = ERR_TOTAL_BIG;
                end
            end
            if (o_res.error_code != ERR_NONE) begin
                o_res.valid     = 1'b1;
                o_res.event_res = EV_ERROR;
            end
        end else if (i_action == ACT_CLOSE && i_ctl.phase != PH_FINAL) begin
            o_res.valid      = 1'b1;
            o_res.event_res  = EV_ERROR;
            o_res.error_code = ERR_CLOSED;
        end
    end

endmodule

`default_nettype wire
